FILE: design/ray_disk_cap_intersect_unit_defines.svh
// Assertion macros shared by the ray and disk intersection unit.
`ifndef RAY_DISK_CAP_INTERSECT_UNIT_DEFINES_SVH
`define RAY_DISK_CAP_INTERSECT_UNIT_DEFINES_SVH

// Implication in the same cycle, checked outside reset.
`define RDCI_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rdci assertion failed");

// Implication into the next cycle, checked also across reset.
`define RDCI_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rdci assertion failed");

`endif

FILE: design/rdci_pkg.sv
// Types and constants of the ray and disk intersection unit.
`default_nettype none
package rdci_pkg;

   localparam int CoordW = 32;
   localparam int NormW  = 18;
   localparam int RadW   = 31;
   localparam int RelW   = 33;
   localparam int DenW   = 52;
   localparam int NumW   = 54;
   localparam int RemW   = 52;
   localparam int QuoW   = 31;
   localparam int DivSteps = QuoW;

   localparam logic [2:0] CsrCenterX = 3'd0;
   localparam logic [2:0] CsrCenterY = 3'd1;
   localparam logic [2:0] CsrCenterZ = 3'd2;
   localparam logic [2:0] CsrNormalX = 3'd3;
   localparam logic [2:0] CsrNormalY = 3'd4;
   localparam logic [2:0] CsrNormalZ = 3'd5;
   localparam logic [2:0] CsrRadius  = 3'd6;

   localparam logic [DenW-1:0] ParallelLimit = DenW'(4295);
   localparam logic [QuoW-1:0] DistMax       = '1;
   localparam logic [QuoW-1:0] MinHitDist    = QuoW'(65);

   typedef struct packed {
      logic [2:0][CoordW-1:0] center;
      logic [2:0][NormW-1:0]  normal;
      logic [RadW-1:0]        radius;
      logic [2*RadW-1:0]      radius_sq;
   } cfg_type;

   typedef struct packed {
      logic [2:0][RelW-1:0]   rel;
      logic [2:0][CoordW-1:0] dir;
      logic                   miss;
      logic                   sat;
   } side_type;

   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [RemW-1:0] dvsr;
      logic [QuoW-1:0] num;
      logic [QuoW-1:0] quo;
      side_type        side;
   } div_type;

endpackage
`default_nettype wire

FILE: design/rdci_csr.sv
// Configuration registers of the disk: center, axis, radius and squared radius.
`default_nettype none
module rdci_csr (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [2:0]             csr_index,
   input  wire logic [31:0]            csr_wdata,
   output rdci_pkg::cfg_type           cfg
);

   rdci_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      cfg_in.radius_sq = 62'(cfg_ff.radius) * 62'(cfg_ff.radius);
      if (csr_we) begin
         case (csr_index)
            rdci_pkg::CsrCenterX: cfg_in.center[0] = csr_wdata;
            rdci_pkg::CsrCenterY: cfg_in.center[1] = csr_wdata;
            rdci_pkg::CsrCenterZ: cfg_in.center[2] = csr_wdata;
            rdci_pkg::CsrNormalX: cfg_in.normal[0] = csr_wdata[rdci_pkg::NormW-1:0];
            rdci_pkg::CsrNormalY: cfg_in.normal[1] = csr_wdata[rdci_pkg::NormW-1:0];
            rdci_pkg::CsrNormalZ: cfg_in.normal[2] = csr_wdata[rdci_pkg::NormW-1:0];
            rdci_pkg::CsrRadius:  cfg_in.radius    = csr_wdata[rdci_pkg::RadW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center    <= '0;
         cfg_ff.normal[0] <= '0;
         cfg_ff.normal[1] <= rdci_pkg::NormW'(65536);
         cfg_ff.normal[2] <= '0;
         cfg_ff.radius    <= rdci_pkg::RadW'(65536);
         cfg_ff.radius_sq <= 62'(65536) * 62'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: design/rdci_dot.sv
// Front stages: relative origin, dot products, parallel and near tests.
`default_nettype none
module rdci_dot (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire logic [2:0][rdci_pkg::CoordW-1:0]   org,
   input  wire logic [2:0][rdci_pkg::CoordW-1:0]   dir,
   input  rdci_pkg::cfg_type                       cfg,
   output logic                                    out_valid,
   output rdci_pkg::div_type                       out_data
);

   logic [4:0] v_ff, v_in;

   rdci_pkg::side_type side1_ff, side1_in, side2_ff, side3_ff, side4_ff;

   logic signed [49:0] pd2_ff [3];
   logic signed [49:0] pd2_in [3];
   logic signed [50:0] pn2_ff [3];
   logic signed [50:0] pn2_in [3];

   logic signed [rdci_pkg::DenW-1:0] d3_ff, d3_in;
   logic signed [rdci_pkg::NumW-1:0] n3_ff, n3_in;

   logic [rdci_pkg::DenW-1:0]        ad4_ff, ad4_in;
   logic signed [rdci_pkg::NumW-1:0] an4_ff, an4_in;
   logic                             par4_ff, par4_in;

   rdci_pkg::div_type div5_ff, div5_in;

   logic signed [63:0] near_scaled;
   logic signed [63:0] ad_wide;
   logic signed [rdci_pkg::NumW-1:0] an_hi;
   logic [rdci_pkg::DenW-1:0] un;

   assign v_in = {v_ff[3:0], in_valid};

   always_comb begin
      side1_in = '0;
      for (int i = 0; i < 3; i++) begin
         side1_in.rel[i] = rdci_pkg::RelW'($signed(org[i]))
                         - rdci_pkg::RelW'($signed(cfg.center[i]));
         side1_in.dir[i] = dir[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pd2_in[i] = 50'($signed(side1_ff.dir[i]) * $signed(cfg.normal[i]));
         pn2_in[i] = 51'($signed(side1_ff.rel[i]) * $signed(cfg.normal[i]));
      end
   end

   always_comb begin
      d3_in = rdci_pkg::DenW'(pd2_ff[0]) + rdci_pkg::DenW'(pd2_ff[1])
            + rdci_pkg::DenW'(pd2_ff[2]);
      n3_in = -(rdci_pkg::NumW'(pn2_ff[0]) + rdci_pkg::NumW'(pn2_ff[1])
            + rdci_pkg::NumW'(pn2_ff[2]));
   end

   always_comb begin
      if (d3_ff < 0) begin
         ad4_in = rdci_pkg::DenW'(-d3_ff);
         an4_in = -n3_ff;
      end else begin
         ad4_in = rdci_pkg::DenW'(d3_ff);
         an4_in = n3_ff;
      end
      par4_in = ad4_in < rdci_pkg::ParallelLimit;
   end

   always_comb begin
      near_scaled = (64'(an4_ff) <<< 10) - (64'(an4_ff) <<< 5) + (64'(an4_ff) <<< 3);
      ad_wide     = $signed(64'(ad4_ff));
      an_hi       = an4_ff >>> 15;
      un          = an4_ff[rdci_pkg::DenW-1:0];
      div5_in          = '0;
      div5_in.side     = side4_ff;
      div5_in.side.miss = par4_ff || (near_scaled < ad_wide);
      div5_in.side.sat  = an_hi >= $signed(rdci_pkg::NumW'(ad4_ff));
      div5_in.rem      = un >> 15;
      div5_in.dvsr     = ad4_ff;
      div5_in.num      = {un[14:0], 16'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff <= side1_in;
      side2_ff <= side1_ff;
      side3_ff <= side2_ff;
      side4_ff <= side3_ff;
      pd2_ff   <= pd2_in;
      pn2_ff   <= pn2_in;
      d3_ff    <= d3_in;
      n3_ff    <= n3_in;
      ad4_ff   <= ad4_in;
      an4_ff   <= an4_in;
      par4_ff  <= par4_in;
      div5_ff  <= div5_in;
   end

   assign out_valid = v_ff[4];
   assign out_data  = div5_ff;

endmodule
`default_nettype wire

FILE: design/rdci_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the ray parameter.
`default_nettype none
module rdci_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  rdci_pkg::div_type               in_data,
   output logic                            out_valid,
   output logic [rdci_pkg::QuoW-1:0]       out_tq,
   output rdci_pkg::side_type              out_side
);

   logic [rdci_pkg::DivSteps-1:0] v_ff, v_in;
   rdci_pkg::div_type st_ff [rdci_pkg::DivSteps];
   rdci_pkg::div_type st_in [rdci_pkg::DivSteps];

   assign v_in = {v_ff[rdci_pkg::DivSteps-2:0], in_valid};

   always_comb begin
      rdci_pkg::div_type prev;
      logic [rdci_pkg::RemW:0] trial;
      logic [rdci_pkg::RemW:0] dv;
      logic qbit;
      for (int k = 0; k < rdci_pkg::DivSteps; k++) begin
         prev  = (k == 0) ? in_data : st_ff[k == 0 ? 0 : k - 1];
         trial = {prev.rem, prev.num[rdci_pkg::QuoW-1]};
         dv    = {1'b0, prev.dvsr};
         qbit  = trial >= dv;
         st_in[k]     = prev;
         st_in[k].rem = qbit ? rdci_pkg::RemW'(trial - dv) : rdci_pkg::RemW'(trial);
         st_in[k].num = {prev.num[rdci_pkg::QuoW-2:0], 1'b0};
         st_in[k].quo = {prev.quo[rdci_pkg::QuoW-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign out_valid = v_ff[rdci_pkg::DivSteps-1];
   assign out_side  = st_ff[rdci_pkg::DivSteps-1].side;
   assign out_tq    = st_ff[rdci_pkg::DivSteps-1].side.sat ? rdci_pkg::DistMax
                                                           : st_ff[rdci_pkg::DivSteps-1].quo;

endmodule
`default_nettype wire

FILE: design/rdci_bound.sv
// Back stages: hit point, radius test and the result register.
`default_nettype none
module rdci_bound (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [rdci_pkg::QuoW-1:0]  in_tq,
   input  rdci_pkg::side_type              in_side,
   input  rdci_pkg::cfg_type               cfg,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [rdci_pkg::QuoW-1:0]       rsp_hit_dist
);

   logic [2:0] v_ff, v_in;

   logic signed [63:0] prod1_ff [3];
   logic signed [63:0] prod1_in [3];
   logic [rdci_pkg::RelW-1:0] rel1_ff [3];
   logic [rdci_pkg::QuoW-1:0] tq1_ff, tq2_ff, tq3_ff;
   logic miss1_ff, miss2_ff, miss3_ff;

   logic [47:0] a2_ff [3];
   logic [47:0] a2_in [3];

   logic [61:0] sq3_ff [3];
   logic [61:0] sq3_in [3];
   logic over3_ff, over3_in;

   logic [63:0] sum;
   logic hit;
   logic valid_ff, hit_ff;
   logic [rdci_pkg::QuoW-1:0] dist_ff;

   assign v_in = {v_ff[1:0], in_valid};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod1_in[i] = $signed({1'b0, in_tq}) * $signed(in_side.dir[i]);
      end
   end

   always_comb begin
      logic signed [47:0] p;
      for (int i = 0; i < 3; i++) begin
         p = 48'($signed(rel1_ff[i])) + $signed(prod1_ff[i][63:16]);
         a2_in[i] = (p < 0) ? 48'(-p) : 48'(p);
      end
   end

   always_comb begin
      over3_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         over3_in  = over3_in | (a2_ff[i] > 48'(cfg.radius));
         sq3_in[i] = 62'(a2_ff[i][30:0]) * 62'(a2_ff[i][30:0]);
      end
   end

   always_comb begin
      sum = 64'(sq3_ff[0]) + 64'(sq3_ff[1]) + 64'(sq3_ff[2]);
      hit = !miss3_ff && !over3_ff && (sum <= 64'(cfg.radius_sq));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         v_ff     <= v_in;
         valid_ff <= v_ff[2];
         hit_ff   <= v_ff[2] && hit;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         rel1_ff[i] <= in_side.rel[i];
      end
      prod1_ff <= prod1_in;
      tq1_ff   <= in_tq;
      miss1_ff <= in_side.miss;
      a2_ff    <= a2_in;
      tq2_ff   <= tq1_ff;
      miss2_ff <= miss1_ff;
      sq3_ff   <= sq3_in;
      over3_ff <= over3_in;
      tq3_ff   <= tq2_ff;
      miss3_ff <= miss2_ff;
      dist_ff  <= hit ? tq3_ff : '0;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_hit_dist = dist_ff;

endmodule
`default_nettype wire

FILE: design/ray_disk_cap_intersect_unit.sv
// Pipeline: 40 register stages lie between a ray transfer and the strobe of its result.
// Throughput: one ray per cycle; busy stays low and every cycle may start a ray.
// The stages are 5 front stages, the 31-stage divider for the ray parameter and 4 back stages.
// Reset clears all valid bits and loads the default disk; rays in flight are dropped.
// Results cannot be held off by the receiver.
`default_nettype none
`include "ray_disk_cap_intersect_unit_defines.svh"
module ray_disk_cap_intersect_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [31:0]                 req_org_x,
   input  wire logic [31:0]                 req_org_y,
   input  wire logic [31:0]                 req_org_z,
   input  wire logic [31:0]                 req_dir_x,
   input  wire logic [31:0]                 req_dir_y,
   input  wire logic [31:0]                 req_dir_z,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic [30:0]                      rsp_hit_dist,
   input  wire logic                        csr_we,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [31:0]                 csr_wdata
);

   rdci_pkg::cfg_type  cfg;
   rdci_pkg::div_type  div_data;
   rdci_pkg::side_type bound_side;
   logic               div_valid;
   logic               bound_valid;
   logic [rdci_pkg::QuoW-1:0] bound_tq;
   logic               transfer;

   assign busy     = 1'b0;
   assign transfer = start && !busy;

   rdci_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rdci_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (transfer),
      .org       ({req_org_z, req_org_y, req_org_x}),
      .dir       ({req_dir_z, req_dir_y, req_dir_x}),
      .cfg       (cfg),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   rdci_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (bound_valid),
      .out_tq    (bound_tq),
      .out_side  (bound_side)
   );

   rdci_bound u_bound (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (bound_valid),
      .in_tq        (bound_tq),
      .in_side      (bound_side),
      .cfg          (cfg),
      .rsp_valid    (rsp_valid),
      .rsp_hit      (rsp_hit),
      .rsp_hit_dist (rsp_hit_dist)
   );

   `RDCI_ASSERT_NEXT(a_reset_clears, reset, !rsp_valid && !rsp_hit)
   `RDCI_ASSERT_IMP(a_hit_has_valid, rsp_hit, rsp_valid)
   `RDCI_ASSERT_IMP(a_miss_zero_dist, rsp_valid && !rsp_hit, rsp_hit_dist == '0)
   `RDCI_ASSERT_IMP(a_hit_min_dist, rsp_hit, rsp_hit_dist >= rdci_pkg::MinHitDist)

endmodule
`default_nettype wire

FILE: tb/ray_disk_cap_intersect_unit_checker.sv
// Checker that predicts and compares every ray result of the disk intersection unit.
`default_nettype none
module ray_disk_cap_intersect_unit_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [31:0] req_org_x,
   input  wire logic [31:0] req_org_y,
   input  wire logic [31:0] req_org_z,
   input  wire logic [31:0] req_dir_x,
   input  wire logic [31:0] req_dir_y,
   input  wire logic [31:0] req_dir_z,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_hit,
   input  wire logic [30:0] rsp_hit_dist,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic        hit;
      logic [30:0] hit_dist;
   } disk_hit_type;

   logic [2:0][31:0] center;
   logic [2:0][17:0] normal;
   logic [30:0]      radius;
   disk_hit_type     pending_hits[$];

   function automatic disk_hit_type trace_disk(input logic [2:0][31:0] org,
                                               input logic [2:0][31:0] dir);
      disk_hit_type res;
      longint rel[3];
      longint dv[3];
      longint o, c, nv, den, num, p;
      longint unsigned ud, un, q0, a, sq, rr;
      logic [127:0] wide;
      logic [30:0] tq;
      res = '0;
      den = 0;
      num = 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         o = longint'($signed(org[i]));
         dv[i] = longint'($signed(dir[i]));
         c = longint'($signed(center[i]));
         nv = longint'($signed(normal[i]));
         rel[i] = o - c;
         den += dv[i] * nv;
         num += (c - o) * nv;
      end
      if (den < 4295 && den > -4295) return res;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num * 1000 < den) return res;
      ud = den;
      un = num;
      q0 = un / ud;
      if (q0 >= 32768) begin
         tq = '1;
      end else begin
         wide = 128'(un) << 16;
         tq = 31'(wide / 128'(ud));
      end
      for (int i = 0; i < 3; i++) begin
         p = rel[i] + ((longint'(tq) * dv[i]) >>> 16);
         a = (p < 0) ? -p : p;
         if (a > longint'(radius)) return res;
         sq += a * a;
      end
      rr = longint'(radius) * longint'(radius);
      if (sq > rr) return res;
      res.hit = 1'b1;
      res.hit_dist = tq;
      return res;
   endfunction

   assign pending_count = pending_hits.size();

   always @(posedge clock) begin
      disk_hit_type want;
      if (reset) begin
         center <= '0;
         normal <= {18'd0, 18'd65536, 18'd0};
         radius <= 31'd65536;
         pending_hits.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rdci_pkg::CsrCenterX: center[0] <= csr_wdata;
               rdci_pkg::CsrCenterY: center[1] <= csr_wdata;
               rdci_pkg::CsrCenterZ: center[2] <= csr_wdata;
               rdci_pkg::CsrNormalX: normal[0] <= csr_wdata[17:0];
               rdci_pkg::CsrNormalY: normal[1] <= csr_wdata[17:0];
               rdci_pkg::CsrNormalZ: normal[2] <= csr_wdata[17:0];
               rdci_pkg::CsrRadius:  radius <= csr_wdata[30:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (pending_hits.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected result transfer: hit %0b dist %0d",
                           rsp_hit, rsp_hit_dist);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_hits.pop_front();
               if (want.hit !== rsp_hit || want.hit_dist !== rsp_hit_dist) begin
                  if (fail_count < 10)
                     $display("Result mismatch: expected hit %0b dist %0d, got hit %0b dist %0d",
                              want.hit, want.hit_dist, rsp_hit, rsp_hit_dist);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            pending_hits.push_back(trace_disk({req_org_z, req_org_y, req_org_x},
                                              {req_dir_z, req_dir_y, req_dir_x}));
      end
   end

endmodule
`default_nettype wire

FILE: tb/ray_disk_cap_intersect_unit_tb.sv
// Stimulus and verdict for the ray and disk intersection unit.
`default_nettype none
module ray_disk_cap_intersect_unit_tb;

   localparam logic [2:0] CsrUnused = 3'd7;
   localparam int CycleLimit = 400000;
   localparam int Unit = 65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [31:0] req_org_x = '0, req_org_y = '0, req_org_z = '0;
   logic [31:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid, rsp_hit;
   logic [30:0] rsp_hit_dist;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int fail_count, pending_count;
   int cycles = 0;

   int cen[3];
   int nrm[3];
   int rad;

   ray_disk_cap_intersect_unit dut (.*);
   ray_disk_cap_intersect_unit_checker disk_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_ray(input int ox, input int oy, input int oz,
                           input int dx, input int dy, input int dz);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_org_x <= ox;
      req_org_y <= oy;
      req_org_z <= oz;
      req_dir_x <= dx;
      req_dir_y <= dy;
      req_dir_z <= dz;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic load_disk(input int cx, input int cy, input int cz,
                            input int nx, input int ny, input int nz, input int r);
      logic [2:0] idx[8];
      int val[8];
      cen = '{cx, cy, cz};
      nrm = '{nx, ny, nz};
      rad = r;
      idx = '{rdci_pkg::CsrCenterX, rdci_pkg::CsrCenterY, rdci_pkg::CsrCenterZ,
              rdci_pkg::CsrNormalX, rdci_pkg::CsrNormalY, rdci_pkg::CsrNormalZ,
              rdci_pkg::CsrRadius, CsrUnused};
      val = '{cx, cy, cz, nx, ny, nz, r, $urandom()};
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Aim a ray at a point near the disk from a random distance along the ray.
   task automatic send_aimed_ray();
      longint tgt[3], dv[3], org[3];
      longint span, tk;
      span = (rad / 2 + 4) * 5 / 2 + 1;
      if (span > 64'h3000_0000) span = 64'h3000_0000;
      tk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 8192);
      for (int i = 0; i < 3; i++) begin
         tgt[i] = longint'(cen[i]) + longint'($urandom_range(0, 2 * 32'(span))) - span;
         dv[i] = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
         org[i] = tgt[i] - ((dv[i] * tk) >>> 9);
      end
      send_ray(32'(org[0]), 32'(org[1]), 32'(org[2]),
               32'(dv[0]), 32'(dv[1]), 32'(dv[2]));
   endtask

   task automatic random_phase(input int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 4) == 0)
            send_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         else
            send_aimed_ray();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      cen = '{0, 0, 0};
      nrm = '{0, Unit, 0};
      rad = Unit;

      send_ray(0, 0, 0, 0, 0, 0);
      send_ray(0, 2 * Unit, 0, 0, -Unit, 0);
      send_ray(Unit / 2, -Unit, 0, 0, Unit, 0);
      send_ray(Unit, Unit, 0, 0, -Unit, 0);
      send_ray(Unit + 1, Unit, 0, 0, -Unit, 0);
      send_ray(0, 0, 0, 0, -Unit, 0);
      send_ray(0, 60, 0, 0, -Unit, 0);
      send_ray(0, 1 << 30, 0, 0, -1, 0);
      send_ray(0, Unit, 0, Unit, Unit, 0);
      send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_ray(0, Unit, 0, 0, 32'h8000_0000, 0);
      send_ray(0, -Unit, 0, 0, 32'h7FFF_FFFF, 0);
      random_phase(80);
      drain();

      load_disk(3 * Unit, -2 * Unit, Unit, 0, 0, -Unit, 2 * Unit);
      random_phase(90);
      drain();

      load_disk(32'h0FFF_0000, -32'h0FFF_0000, 32'h0100_0000, 46341, 0, 46341, 7 * Unit);
      random_phase(90);
      drain();

      load_disk(32'h7FFF_FFFF, 32'h8000_0000, 0, -Unit, 0, 0, 0);
      send_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, -Unit, 0, 0);
      random_phase(60);
      drain();

      load_disk(0, 0, 0, 37837, -37837, 37837, 32'h7FFF_FFFF);
      random_phase(90);
      drain();

      load_disk(-5 * Unit, Unit / 3, 9 * Unit, 0, Unit, 0, Unit / 4);
      random_phase(110);
      drain();

      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
